/* design/emi17_pkg.sv */
// emi17_pkg: types, constants and microcode rom for the mod 2^17-1 inverse
// no dependencies; used by every other file of the block
package emi17_pkg;

  localparam int unsigned DATA_W = 17;
  localparam logic [DATA_W-1:0] MODULUS = 17'h1FFFF;

  localparam int unsigned ROM_DEPTH = 4;
  localparam int unsigned PC_W = $clog2(ROM_DEPTH);

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [1:0] {
    OP_IDLE   = 2'd0,
    OP_REDUCE = 2'd1,
    OP_EMIT   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    COND_IN_TAKEN = 2'd0,
    COND_A_ZERO   = 2'd1,
    COND_OUT_FREE = 2'd2,
    COND_ALWAYS   = 2'd3
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    pc_t   jmp_true;
    pc_t   jmp_false;
  } ucode_t;

  // step addresses
  localparam pc_t PC_WAIT   = 2'd0;
  localparam pc_t PC_REDUCE = 2'd1;
  localparam pc_t PC_EMIT   = 2'd2;
  localparam pc_t PC_SPARE  = 2'd3;

  typedef struct packed {
    op_e op;
  } ctrl_t;

  typedef struct packed {
    logic in_taken;
    logic a_zero;
    logic out_free;
  } status_t;

  function automatic ucode_t rom_word(pc_t pc);
    ucode_t w;
    unique case (pc)
      PC_WAIT:   w = '{op: OP_IDLE,   cond: COND_IN_TAKEN, jmp_true: PC_REDUCE,
                       jmp_false: PC_WAIT};
      PC_REDUCE: w = '{op: OP_REDUCE, cond: COND_A_ZERO,   jmp_true: PC_EMIT,
                       jmp_false: PC_REDUCE};
      PC_EMIT:   w = '{op: OP_EMIT,   cond: COND_OUT_FREE, jmp_true: PC_WAIT,
                       jmp_false: PC_EMIT};
      PC_SPARE:  w = '{op: OP_NOP,    cond: COND_ALWAYS,   jmp_true: PC_WAIT,
                       jmp_false: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* design/emi17_if.sv */
// emi17 channel interfaces: input item and result item, valid/ready
// depends on emi17_pkg
interface emi17_in_if;
  logic                 valid;
  logic                 ready;
  emi17_pkg::data_t     value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface emi17_out_if;
  logic                 valid;
  logic                 ready;
  emi17_pkg::data_t     inverse;
  logic                 no_inverse;

  modport source (output valid, output inverse, output no_inverse, input ready);
  modport sink (input valid, input inverse, input no_inverse, output ready);
endinterface

/* design/emi17_seq.sv */
// emi17_seq: step counter and microcode rom with conditional jumps
// depends on emi17_pkg
module emi17_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  emi17_pkg::status_t  status_i,
  output emi17_pkg::ctrl_t    ctrl_o
);

  emi17_pkg::pc_t    pc_q, pc_d;
  emi17_pkg::ucode_t word;
  logic              cond_hit;

  assign word = emi17_pkg::rom_word(pc_q);

  always_comb begin
    unique case (word.cond)
      emi17_pkg::COND_IN_TAKEN: cond_hit = status_i.in_taken;
      emi17_pkg::COND_A_ZERO:   cond_hit = status_i.a_zero;
      emi17_pkg::COND_OUT_FREE: cond_hit = status_i.out_free;
      default:                  cond_hit = 1'b1;
    endcase
  end

  assign pc_d      = cond_hit ? word.jmp_true : word.jmp_false;
  assign ctrl_o.op = word.op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= emi17_pkg::PC_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* design/emi17_dp.sv */
// emi17_dp: binary extended euclid datapath with halving and subtraction mod p
// depends on emi17_pkg and emi17_if
module emi17_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  emi17_pkg::ctrl_t     ctrl_i,
  output emi17_pkg::status_t   status_o,
  emi17_in_if.sink             in_i,
  emi17_out_if.source          out_o
);

  emi17_pkg::data_t a_q, b_q, u_q, v_q;
  logic             err_q;
  emi17_pkg::data_t res_q;
  logic             res_err_q;
  logic             res_valid_q;

  logic             in_taken;
  logic             out_free;
  logic             a_lt_b;
  emi17_pkg::data_t a_diff;
  emi17_pkg::data_t u_half;
  emi17_pkg::data_t u_sub, u_sub_fix;
  logic [emi17_pkg::DATA_W:0] u_plus_p;
  logic [emi17_pkg::DATA_W:0] sub_raw;

  assign in_i.ready = (ctrl_i.op == emi17_pkg::OP_IDLE);
  assign in_taken   = in_i.valid && in_i.ready;
  assign out_free   = !res_valid_q || out_o.ready;

  assign status_o.in_taken = in_taken;
  assign status_o.a_zero   = (a_q == '0);
  assign status_o.out_free = out_free;

  // halving mod p: odd values get p added first
  assign u_plus_p = {1'b0, u_q} + {1'b0, emi17_pkg::MODULUS};
  assign u_half   = u_q[0] ? u_plus_p[emi17_pkg::DATA_W:1] : (u_q >> 1);

  // odd a: subtract the smaller from the larger, coefficients follow mod p
  assign a_lt_b  = (a_q < b_q);
  assign a_diff  = a_lt_b ? (b_q - a_q) : (a_q - b_q);
  assign sub_raw = a_lt_b ? ({1'b0, v_q} - {1'b0, u_q}) : ({1'b0, u_q} - {1'b0, v_q});
  assign u_sub   = sub_raw[emi17_pkg::DATA_W-1:0];
  assign u_sub_fix = sub_raw[emi17_pkg::DATA_W] ? (u_sub + emi17_pkg::MODULUS) : u_sub;

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      emi17_pkg::OP_IDLE: begin
        if (in_taken) begin
          a_q   <= in_i.value;
          b_q   <= emi17_pkg::MODULUS;
          u_q   <= emi17_pkg::data_t'(1);
          v_q   <= '0;
          err_q <= (in_i.value == '0) || (in_i.value == emi17_pkg::MODULUS);
        end
      end
      emi17_pkg::OP_REDUCE: begin
        if (!a_q[0]) begin
          a_q <= a_q >> 1;
          u_q <= u_half;
        end else begin
          a_q <= a_diff;
          u_q <= u_sub_fix;
          if (a_lt_b) begin
            b_q <= a_q;
            v_q <= u_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if ((ctrl_i.op == emi17_pkg::OP_EMIT) && out_free) begin
      res_q     <= err_q ? '0 : v_q;
      res_err_q <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if ((ctrl_i.op == emi17_pkg::OP_EMIT) && out_free) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  assign out_o.valid      = res_valid_q;
  assign out_o.inverse    = res_q;
  assign out_o.no_inverse = res_err_q;

endmodule

/* design/euclid_inverse_mersenne17_top.sv */
// euclid_inverse_mersenne17_top: inverse modulo 2^17-1, microcoded sequencer and datapath
// depends on emi17_pkg, emi17_if, emi17_seq and emi17_dp
//
//   channel  dir  handshake    payload
//   in_i     in   valid/ready  value[16:0]
//   out_o    out  valid/ready  inverse[16:0], no_inverse
//
// one item at a time: the item is taken, then one reduction step per cycle
// (halve or subtract) until the working value is zero, then the result is emitted
// the result register lets the next item enter while a result waits; reset
// clears the step counter and the result valid flag
module euclid_inverse_mersenne17_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  emi17_in_if.sink     in_i,
  emi17_out_if.source  out_o
);

  emi17_pkg::ctrl_t   ctrl;
  emi17_pkg::status_t status;

  emi17_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  emi17_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .status_o (status),
    .in_i     (in_i),
    .out_o    (out_o)
  );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// tb_top: self-checking bench for the inverse modulo 2^17-1, a directed table then random items
// depends on emi17_pkg, emi17_if and euclid_inverse_mersenne17_top
module tb_top;

  localparam int unsigned RANDOM_ITEMS  = 430;
  localparam int unsigned IDLE_PCT      = 31;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned DIR_ROWS      = 20;

  typedef struct packed {
    emi17_pkg::data_t value;
    emi17_pkg::data_t inverse;
    logic             no_inverse;
  } inv_result_t;

  typedef struct packed {
    emi17_pkg::data_t value;
    logic             typed;
    emi17_pkg::data_t inverse;
    logic             no_inverse;
  } dir_row_t;

  // typed rows carry their own answer, the rest go through the predictor
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{17'h00000, 1'b1, 17'h00000, 1'b1},
    '{17'h1FFFF, 1'b1, 17'h00000, 1'b1},
    '{17'h00001, 1'b1, 17'h00001, 1'b0},
    '{17'h1FFFE, 1'b1, 17'h1FFFE, 1'b0},
    '{17'h00002, 1'b1, 17'h10000, 1'b0},
    '{17'h10000, 1'b1, 17'h00002, 1'b0},
    '{17'h00003, 1'b0, 17'h00000, 1'b0},
    '{17'h0AAAA, 1'b0, 17'h00000, 1'b0},
    '{17'h15555, 1'b0, 17'h00000, 1'b0},
    '{17'h1FFFD, 1'b0, 17'h00000, 1'b0},
    '{17'h00FFF, 1'b0, 17'h00000, 1'b0},
    '{17'h1F000, 1'b0, 17'h00000, 1'b0},
    '{17'h12345, 1'b0, 17'h00000, 1'b0},
    '{17'h0BEEF, 1'b0, 17'h00000, 1'b0},
    '{17'h00100, 1'b0, 17'h00000, 1'b0},
    '{17'h1E001, 1'b0, 17'h00000, 1'b0},
    '{17'h00000, 1'b1, 17'h00000, 1'b1},
    '{17'h1FFFF, 1'b1, 17'h00000, 1'b1},
    '{17'h00001, 1'b1, 17'h00001, 1'b0},
    '{17'h0FFFF, 1'b0, 17'h00000, 1'b0}
  };

  logic        clk;
  logic        rst_n;
  bit          steady_run;
  int unsigned mismatch_count;
  inv_result_t expected_inverses [$];

  emi17_in_if  in_ch ();
  emi17_out_if out_ch ();

  euclid_inverse_mersenne17_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic inv_result_t predict_inverse(emi17_pkg::data_t v);
    inv_result_t res;
    longint      r_prev;
    longint      r_cur;
    longint      r_next;
    longint      c_prev;
    longint      c_cur;
    longint      c_next;
    longint      q;
    res.value      = v;
    res.inverse    = '0;
    res.no_inverse = 1'b1;
    if (v == '0 || v == emi17_pkg::MODULUS) return res;
    r_prev = longint'(emi17_pkg::MODULUS);
    r_cur  = longint'(v);
    c_prev = 0;
    c_cur  = 1;
    while (r_cur != 0) begin
      q      = r_prev / r_cur;
      r_next = r_prev - q * r_cur;
      c_next = c_prev - q * c_cur;
      r_prev = r_cur;
      r_cur  = r_next;
      c_prev = c_cur;
      c_cur  = c_next;
    end
    if (c_prev < 0) c_prev += longint'(emi17_pkg::MODULUS);
    res.inverse    = emi17_pkg::data_t'(c_prev);
    res.no_inverse = 1'b0;
    return res;
  endfunction

  function automatic emi17_pkg::data_t pick_value();
    int unsigned      sel;
    emi17_pkg::data_t one_hot;
    sel     = $urandom_range(99);
    one_hot = emi17_pkg::data_t'(1) << $urandom_range(emi17_pkg::DATA_W - 1);
    if (sel < 3) return '0;
    if (sel < 6) return emi17_pkg::MODULUS;
    if (sel < 8) return emi17_pkg::data_t'(1);
    if (sel < 10) return emi17_pkg::MODULUS - emi17_pkg::data_t'(1);
    if (sel < 15) return one_hot;
    if (sel < 20) return emi17_pkg::MODULUS ^ one_hot;
    return emi17_pkg::data_t'($urandom_range(32'h1FFFF));
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_value(input emi17_pkg::data_t v, input inv_result_t want);
    int unsigned gap;
    gap = 0;
    if (!steady_run && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(4, 1);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    expected_inverses.push_back(want);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_inverses.size() != 0);
  endtask

  always @(negedge clk) begin
    out_ch.ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    inv_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_inverses.size() == 0) begin
        note_mismatch($sformatf("item with none pending: inverse %h no_inverse %b",
                                out_ch.inverse, out_ch.no_inverse));
      end else begin
        want = expected_inverses.pop_front();
        if (out_ch.inverse !== want.inverse || out_ch.no_inverse !== want.no_inverse) begin
          note_mismatch($sformatf("value %h: expected %h/%b, got %h/%b", want.value,
                                  want.inverse, want.no_inverse, out_ch.inverse,
                                  out_ch.no_inverse));
        end
      end
    end
  end

  initial begin
    inv_result_t      want;
    emi17_pkg::data_t v;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    out_ch.ready   = 1'b0;
    steady_run     = 1'b0;
    mismatch_count = 0;
    rst_n          = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].typed) begin
        want = '{directed_rows[i].value, directed_rows[i].inverse,
                 directed_rows[i].no_inverse};
      end else begin
        want = predict_inverse(directed_rows[i].value);
      end
      send_value(directed_rows[i].value, want);
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100) hold_until_drained();
      steady_run = (n >= 150 && n < 250);
      v = pick_value();
      send_value(v, predict_inverse(v));
    end
    steady_run  = 1'b0;
    in_ch.valid <= 1'b0;

    while (expected_inverses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_inverses.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
design/emi17_pkg.sv
design/emi17_if.sv
design/emi17_seq.sv
design/emi17_dp.sv
design/euclid_inverse_mersenne17_top.sv
tb/sv/tb_top.sv
